[hdl/dda_line_pixel_stepper_unit_macros.svh]
// Assertion macros shared by the line pixel stepper RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef DDA_LINE_PIXEL_STEPPER_UNIT_MACROS_SVH
`define DDA_LINE_PIXEL_STEPPER_UNIT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define DLPS_ASSERT(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check that a condition implies another one in the next cycle.
`define DLPS_ASSERT_NEXT(name, clk, rstn, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error(msg);

`endif

[hdl/dlps_pkg.sv]
// Package for the line pixel stepper: payload structs, codes, FSM state,
// and controller/datapath command and status types. No dependencies.
package dlps_pkg;

  localparam int unsigned COORD_BITS = 12;
  localparam int unsigned DIFF_BITS  = COORD_BITS + 1;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_STEP = 1'b1;

  typedef struct packed {
    logic                         req_type;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
  } dlps_in_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] pixel_x;
    logic signed [COORD_BITS-1:0] pixel_y;
    logic                         last_pixel;
  } dlps_out_t;

  typedef enum logic {
    ST_IDLE,
    ST_DIV
  } dlps_state_e;

  typedef struct packed {
    logic load;    // latch line setup, start the divider
    logic step;    // emit the current pixel and advance
    logic finish;  // write the minor increment from the quotient
  } dlps_cmd_t;

  typedef struct packed {
    logic div_done;
    logic have_pixels;
  } dlps_sts_t;

endpackage

[hdl/dlps_div.sv]
// Iterative restoring divider for unsigned operands, one quotient bit per cycle.
// Standalone; used by dlps_datapath for the minor increment.
module dlps_div #(
  parameter int unsigned DIVIDEND_W = 29,
  parameter int unsigned DIVISOR_W  = 13
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic [DIVIDEND_W-1:0] quotient_o,
  output logic                  done_o
);

  localparam int unsigned CNT_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic [DIVISOR_W-1:0]  rem_q, rem_d;
  logic [DIVISOR_W-1:0]  dvs_q, dvs_d;
  logic [DIVISOR_W:0]    rem_shift;
  logic [DIVISOR_W:0]    rem_sub;
  logic                  fits;

  always_comb begin
    rem_shift = {rem_q, quo_q[DIVIDEND_W-1]};
    rem_sub   = rem_shift - {1'b0, dvs_q};
    fits      = (rem_shift >= {1'b0, dvs_q});
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[DIVIDEND_W-2:0], fits};
      rem_d = fits ? rem_sub[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(DIVIDEND_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

[hdl/dlps_datapath.sv]
// Line stepper datapath: endpoint setup, minor accumulator, major counter,
// output register. Depends on dlps_pkg and dlps_div.
module dlps_datapath #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dlps_pkg::dlps_cmd_t cmd_i,
  output dlps_pkg::dlps_sts_t sts_o,
  input  dlps_pkg::dlps_in_t  in_data_i,
  output dlps_pkg::dlps_out_t out_data_o
);
  import dlps_pkg::*;

  localparam int unsigned ACC_W = DIFF_BITS + FRAC_BITS;

  logic signed [DIFF_BITS-1:0] dx, dy, mdelta;
  logic [DIFF_BITS-1:0]        adx, ady, len, amdelta;
  logic                        sel_x;
  logic [COORD_BITS-1:0]       mstart, major_start;
  logic [ACC_W-1:0]            dividend, quotient, neg_quotient;
  logic                        div_done;

  logic [COORD_BITS-1:0] major_q, major_d;
  logic [ACC_W-1:0]      accum_q, accum_d;
  logic [ACC_W-1:0]      inc_q, inc_d;
  logic                  neg_q, neg_d;
  logic                  is_x_q, is_x_d;
  logic [DIFF_BITS-1:0]  left_q, left_d;
  logic                  mneg_q, mneg_d;
  logic                  zero_len_q, zero_len_d;
  dlps_out_t             out_q, out_d;

  logic [ACC_W-1:0]      minor_adj;
  logic [COORD_BITS-1:0] minor_int;

  // Line setup from the endpoints
  always_comb begin
    dx = $signed({in_data_i.end_x[COORD_BITS-1], in_data_i.end_x})
       - $signed({in_data_i.start_x[COORD_BITS-1], in_data_i.start_x});
    dy = $signed({in_data_i.end_y[COORD_BITS-1], in_data_i.end_y})
       - $signed({in_data_i.start_y[COORD_BITS-1], in_data_i.start_y});
    adx         = dx[DIFF_BITS-1] ? DIFF_BITS'(-dx) : DIFF_BITS'(dx);
    ady         = dy[DIFF_BITS-1] ? DIFF_BITS'(-dy) : DIFF_BITS'(dy);
    sel_x       = (adx >= ady);
    len         = sel_x ? adx : ady;
    amdelta     = sel_x ? ady : adx;
    mdelta      = sel_x ? dy : dx;
    mstart      = sel_x ? in_data_i.start_y : in_data_i.start_x;
    major_start = sel_x ? in_data_i.start_x : in_data_i.start_y;
    dividend    = {amdelta, {FRAC_BITS{1'b0}}};
  end

  dlps_div #(
    .DIVIDEND_W(ACC_W),
    .DIVISOR_W (DIFF_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.load),
    .dividend_i (dividend),
    .divisor_i  (len),
    .quotient_o (quotient),
    .done_o     (div_done)
  );

  assign neg_quotient = ACC_W'(-quotient);

  // Truncate the minor coordinate toward zero
  always_comb begin
    minor_adj = accum_q + (accum_q[ACC_W-1] ? {{DIFF_BITS{1'b0}}, {FRAC_BITS{1'b1}}}
                                            : {ACC_W{1'b0}});
    minor_int = minor_adj[FRAC_BITS +: COORD_BITS];
  end

  always_comb begin
    major_d    = major_q;
    accum_d    = accum_q;
    inc_d      = inc_q;
    neg_d      = neg_q;
    is_x_d     = is_x_q;
    left_d     = left_q;
    mneg_d     = mneg_q;
    zero_len_d = zero_len_q;
    out_d      = out_q;
    if (cmd_i.load) begin
      major_d    = major_start;
      accum_d    = {{(DIFF_BITS - COORD_BITS){mstart[COORD_BITS-1]}}, mstart,
                    {FRAC_BITS{1'b0}}};
      neg_d      = sel_x ? dx[DIFF_BITS-1] : dy[DIFF_BITS-1];
      is_x_d     = sel_x;
      left_d     = len;
      mneg_d     = mdelta[DIFF_BITS-1];
      zero_len_d = (len == '0);
    end
    if (cmd_i.finish) begin
      inc_d = zero_len_q ? '0 : (mneg_q ? neg_quotient : quotient);
    end
    if (cmd_i.step) begin
      out_d.pixel_x    = is_x_q ? major_q : minor_int;
      out_d.pixel_y    = is_x_q ? minor_int : major_q;
      out_d.last_pixel = (left_q == DIFF_BITS'(1));
      major_d          = neg_q ? major_q - COORD_BITS'(1) : major_q + COORD_BITS'(1);
      accum_d          = accum_q + inc_q;
      left_d           = left_q - DIFF_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      major_q    <= '0;
      accum_q    <= '0;
      inc_q      <= '0;
      neg_q      <= 1'b0;
      is_x_q     <= 1'b1;
      left_q     <= '0;
      mneg_q     <= 1'b0;
      zero_len_q <= 1'b1;
    end else begin
      major_q    <= major_d;
      accum_q    <= accum_d;
      inc_q      <= inc_d;
      neg_q      <= neg_d;
      is_x_q     <= is_x_d;
      left_q     <= left_d;
      mneg_q     <= mneg_d;
      zero_len_q <= zero_len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign sts_o.div_done    = div_done;
  assign sts_o.have_pixels = (left_q != '0);
  assign out_data_o        = out_q;

endmodule

[hdl/dlps_ctrl.sv]
// Line stepper controller: accepts transactions, sequences the load divide,
// and owns the output valid flag. Depends on dlps_pkg and the macros header.
`include "dda_line_pixel_stepper_unit_macros.svh"

module dlps_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                req_type_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  dlps_pkg::dlps_sts_t sts_i,
  output dlps_pkg::dlps_cmd_t cmd_o
);
  import dlps_pkg::*;

  dlps_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        in_accept;
  dlps_cmd_t   cmd;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd.load) state_d = ST_DIV;
      end
      ST_DIV: begin
        if (sts_i.div_done) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_stall_o = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
    in_accept  = in_valid_i && !in_stall_o;
    cmd.load   = in_accept && (req_type_i == REQ_LOAD);
    // drop a step request when the line is exhausted
    cmd.step   = in_accept && (req_type_i == REQ_STEP) && sts_i.have_pixels;
    cmd.finish = (state_q == ST_DIV) && sts_i.div_done;
    if (cmd.step) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

  `DLPS_ASSERT_NEXT(a_load_enters_div, clk_i, rst_ni, cmd.load, state_q == ST_DIV, "load did not start divide")
  `DLPS_ASSERT(a_no_overwrite, clk_i, rst_ni, !(cmd.step && out_valid_q && out_stall_i), "pending pixel overwritten")
  `DLPS_ASSERT(a_done_in_div, clk_i, rst_ni, !sts_i.div_done || (state_q == ST_DIV), "divider done outside divide")
  `DLPS_ASSERT(a_cmd_exclusive, clk_i, rst_ni, !(cmd.load && cmd.step), "load and step together")

endmodule

[hdl/dda_line_pixel_stepper_unit.sv]
// Line pixel stepper top level: joins the controller and the datapath.
// Depends on dlps_pkg, dlps_ctrl, dlps_datapath and dlps_div.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries two kinds of
//   transaction. A load (req_type 0) sets up a line from start to end point;
//   it gives no result. A step (req_type 1) emits the next pixel of the line
//   on the output channel (out_valid_o / out_stall_i / out_data_o), with
//   last_pixel set on the final one. The end point itself is never emitted;
//   a step with no pixels left gives no result.
//   A pixel appears in the output register in the cycle after its step
//   is accepted. Steps are taken one per cycle while the output drains.
//   A load starts a divide: the minor increment comes from a restoring
//   divider producing one quotient bit per cycle; no transaction is
//   accepted until it finishes.
//   When the receiver stalls, the pending pixel holds in the output register
//   and in_stall_o stays high for as long as it waits.
//   Reset clears any loaded line (no pixels left, x major) and drops the
//   pending output.
module dda_line_pixel_stepper_unit #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  dlps_pkg::dlps_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output dlps_pkg::dlps_out_t out_data_o
);
  import dlps_pkg::*;

  dlps_cmd_t cmd;
  dlps_sts_t sts;

  dlps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .req_type_i  (in_data_i.req_type),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  dlps_datapath #(
    .FRAC_BITS(FRAC_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o)
  );

endmodule

[tb/dlps_pixel_checker.sv]
// Checker for the line pixel stepper: watches both channels, predicts every pixel
// and compares it with what the block emits. Depends on dlps_pkg.
module dlps_pixel_checker #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  dlps_pkg::dlps_in_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  dlps_pkg::dlps_out_t out_data_i,
  output int                  fail_count_o,
  output int                  pending_o,
  output int                  loads_o,
  output int                  pixels_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import dlps_pkg::*;

  // Line walk state
  longint    major_pos;
  longint    minor_fx;
  longint    minor_step_fx;
  logic      major_down;
  logic      x_major;
  int        pixels_todo;

  dlps_out_t pending_pixels[$];
  int        fails;
  int        loads;
  int        checked;

  function automatic void walk_line(dlps_in_t req);
    longint    one;
    longint    sx, sy, ex, ey, dx, dy, adx, ady;
    longint    span, mstart, mdelta, minor;
    dlps_out_t px;
    one = longint'(1) << FRAC_BITS;
    if (req.req_type == REQ_LOAD) begin
      sx = longint'(req.start_x);
      sy = longint'(req.start_y);
      ex = longint'(req.end_x);
      ey = longint'(req.end_y);
      dx = ex - sx;
      dy = ey - sy;
      adx = (dx < 0) ? -dx : dx;
      ady = (dy < 0) ? -dy : dy;
      x_major = (adx >= ady);
      if (x_major) begin
        span = adx;
        major_pos = sx;
        major_down = (dx < 0);
        mstart = sy;
        mdelta = dy;
      end else begin
        span = ady;
        major_pos = sy;
        major_down = (dy < 0);
        mstart = sx;
        mdelta = dx;
      end
      minor_fx = mstart * one;
      // quotient truncates toward zero
      minor_step_fx = (span > 0) ? (mdelta * one) / span : 0;
      pixels_todo = int'(span);
    end else if (pixels_todo != 0) begin
      minor = (minor_fx < 0) ? -((-minor_fx) >> FRAC_BITS) : (minor_fx >> FRAC_BITS);
      px.pixel_x = x_major ? major_pos[COORD_BITS-1:0] : minor[COORD_BITS-1:0];
      px.pixel_y = x_major ? minor[COORD_BITS-1:0] : major_pos[COORD_BITS-1:0];
      px.last_pixel = (pixels_todo == 1);
      pending_pixels.push_back(px);
      major_pos += major_down ? -1 : 1;
      minor_fx += minor_step_fx;
      pixels_todo--;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    dlps_out_t want;
    if (!rst_ni) begin
      major_pos = 0;
      minor_fx = 0;
      minor_step_fx = 0;
      major_down = 1'b0;
      x_major = 1'b1;
      pixels_todo = 0;
      pending_pixels.delete();
      fails = 0;
      loads = 0;
      checked = 0;
    end else begin
      // Check the output first so a pixel can never match a step taken at this edge
      if (out_valid_i && !out_stall_i) begin
        if (pending_pixels.size() == 0) begin
          fails++;
          $display("%0t ns: unexpected pixel: expected none, got (%0d,%0d,last=%0b)",
                   $time, out_data_i.pixel_x, out_data_i.pixel_y, out_data_i.last_pixel);
        end else begin
          want = pending_pixels.pop_front();
          checked++;
          if (out_data_i.pixel_x !== want.pixel_x || out_data_i.pixel_y !== want.pixel_y ||
              out_data_i.last_pixel !== want.last_pixel) begin
            fails++;
            $display("%0t ns: pixel mismatch: expected (%0d,%0d,last=%0b), got (%0d,%0d,last=%0b)",
                     $time, want.pixel_x, want.pixel_y, want.last_pixel,
                     out_data_i.pixel_x, out_data_i.pixel_y, out_data_i.last_pixel);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (in_data_i.req_type == REQ_LOAD) loads++;
        walk_line(in_data_i);
      end
    end
    fail_count_o <= fails;
    pending_o <= pending_pixels.size();
    loads_o <= loads;
    pixels_o <= checked;
  end

endmodule

[tb/tb.sv]
// Testbench top for the line pixel stepper: clock, reset, line stimulus and verdict.
// Depends on dlps_pkg, dda_line_pixel_stepper_unit and dlps_pixel_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dlps_pkg::*;

  localparam int unsigned FRAC      = 16;
  localparam int          COORD_MIN = -(2 ** (COORD_BITS - 1));
  localparam int          COORD_MAX = 2 ** (COORD_BITS - 1) - 1;
  localparam int          PHASE_LEN = 330;
  localparam int          DRAIN_MAX = 20000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  dlps_in_t  in_data = '0;
  logic      out_stall = 1'b0;
  logic      in_stall;
  logic      out_valid;
  dlps_out_t out_data;
  int        fail_count;
  int        pending;
  int        loads;
  int        pixels;

  int        send_pct = 0;
  int        recv_pct = 0;
  int        sent = 0;

  dda_line_pixel_stepper_unit #(
    .FRAC_BITS(FRAC)
  ) u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  dlps_pixel_checker #(
    .FRAC_BITS(FRAC)
  ) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .loads_o     (loads),
    .pixels_o    (pixels)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < recv_pct);
  end

  function automatic int rand_coord();
    return int'($urandom_range(COORD_MAX - COORD_MIN)) + COORD_MIN;
  endfunction

  // Keep the far end on screen: mirror the offset when it would leave the range
  function automatic int end_from(int s, int d);
    int e;
    e = s + d;
    if (e > COORD_MAX || e < COORD_MIN) e = s - d;
    return e;
  endfunction

  function automatic int line_len(int sx, int sy, int ex, int ey);
    int adx, ady;
    adx = (ex > sx) ? ex - sx : sx - ex;
    ady = (ey > sy) ? ey - sy : sy - ey;
    return (adx >= ady) ? adx : ady;
  endfunction

  function automatic dlps_in_t line_req(int sx, int sy, int ex, int ey);
    dlps_in_t r;
    r.req_type = REQ_LOAD;
    r.start_x = COORD_BITS'(sx);
    r.start_y = COORD_BITS'(sy);
    r.end_x = COORD_BITS'(ex);
    r.end_y = COORD_BITS'(ey);
    return r;
  endfunction

  task automatic send_req(dlps_in_t r);
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  // Steps carry random coordinates; the block ignores them
  task automatic step_line(int n);
    dlps_in_t r;
    repeat (n) begin
      r = line_req(rand_coord(), rand_coord(), rand_coord(), rand_coord());
      r.req_type = REQ_STEP;
      send_req(r);
    end
  endtask

  task automatic load_and_walk(int sx, int sy, int ex, int ey, int steps);
    send_req(line_req(sx, sy, ex, ey));
    step_line((steps > 0) ? steps : 0);
  endtask

  initial begin
    int sx, sy, ex, ey, len, kind, steps;
    int n;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_pct = 24;
    recv_pct = 78;
    step_line(1);                                       // nothing loaded yet
    load_and_walk(5, 5, 5, 5, 1);                       // zero-length line
    send_req(line_req(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX));  // tie goes to x
    step_line(3);
    send_req(line_req(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN));  // major runs down
    step_line(2);
    load_and_walk(0, 0, -3, 7, 8);                      // y major, run past the end
    load_and_walk(10, -1, 13, -3, 3);                   // negative minor truncates toward zero
    send_req(line_req(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN));  // replaced mid-walk
    step_line(1);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_pct = 24;
          recv_pct = 78;
        end
        1: begin
          send_pct = 78;
          recv_pct = 24;
        end
        default: begin
          send_pct = 0;
          recv_pct = 0;
        end
      endcase
      while (sent < 25 + (phase + 1) * PHASE_LEN) begin
        kind = $urandom_range(99);
        sx = rand_coord();
        sy = rand_coord();
        if (kind < 65) begin
          ex = end_from(sx, int'($urandom_range(32)) - 16);
          ey = end_from(sy, int'($urandom_range(32)) - 16);
          len = line_len(sx, sy, ex, ey);
          // now and then cut the walk short and let the next load replace it
          steps = ($urandom_range(9) == 0) ? len - int'($urandom_range(3))
                                           : len + int'($urandom_range(2));
          load_and_walk(sx, sy, ex, ey, steps);
        end else if (kind < 82) begin
          ex = end_from(sx, int'($urandom_range(128)) - 64);
          ey = end_from(sy, int'($urandom_range(128)) - 64);
          len = line_len(sx, sy, ex, ey);
          load_and_walk(sx, sy, ex, ey, len + int'($urandom_range(1)));
        end else if (kind < 90) begin
          ex = rand_coord();
          ey = rand_coord();
          len = line_len(sx, sy, ex, ey);
          n = $urandom_range(1, 12);
          load_and_walk(sx, sy, ex, ey, (len < n) ? len : n);
        end else if (kind < 95) begin
          load_and_walk(sx, sy, sx, sy, $urandom_range(2));
        end else begin
          step_line($urandom_range(1, 3));
        end
      end
    end
    in_valid <= 1'b0;

    n = 0;
    do begin
      @(posedge clk);
      n++;
    end while (pending != 0 && n < DRAIN_MAX);
    if (pending != 0) begin
      $display("Timed out with %0d pixels still expected", pending);
      $display("FAIL");
      $finish;
    end else begin
      repeat (40) @(posedge clk);
      $display("Sent %0d transactions: %0d line loads, %0d pixels compared,", sent, loads,
               pixels);
      $display("under three sender/receiver idle profiles; %0d failures", fail_count);
      if (fail_count == 0) begin
        $display("PASS");
      end else begin
        $display("FAIL");
      end
      $finish;
    end
  end

  initial begin
    #5000000;
    $display("Run time limit reached");
    $display("FAIL");
    $finish;
  end

endmodule

[files.f]
+incdir+hdl
hdl/dlps_pkg.sv
hdl/dlps_div.sv
hdl/dlps_datapath.sv
hdl/dlps_ctrl.sv
hdl/dda_line_pixel_stepper_unit.sv
tb/dlps_pixel_checker.sv
tb/tb.sv
